// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/qfmpi_pkg.sv =====
// ----------------------------------------------------------------------------
// qfmpi_pkg
// Types, micro-program and helpers for the quadratic extension field unit.
// ----------------------------------------------------------------------------
package qfmpi_pkg;

    localparam int WORD_BITS = 64;
    localparam int CNT_W     = $clog2(WORD_BITS);
    localparam int PC_W      = 7;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [PC_W-1:0]      pc_t;

    typedef enum logic [1:0] {
        OPC_MUL = 2'd0,
        OPC_POW = 2'd1,
        OPC_INV = 2'd2,
        OPC_BAD = 2'd3
    } opc_t;

    typedef enum logic [3:0] {
        SEL_XR, SEL_XI, SEL_YR, SEL_YI, SEL_ZR, SEL_ZI, SEL_U,  SEL_T0,
        SEL_T1, SEL_T2, SEL_T3, SEL_R0, SEL_R1, SEL_A0, SEL_A1, SEL_Q
    } sel_t;

    typedef enum logic [4:0] {
        OP_MOD, OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_NEG, OP_MOV, OP_ONE,
        OP_ZERO, OP_LDP, OP_SHE,
        OP_BSMALL, OP_DISP, OP_BZ, OP_BNE1, OP_BEB, OP_LOOP, OP_JMP,
        OP_CALL, OP_RET, OP_SETF, OP_END
    } op_t;

    typedef struct packed {
        op_t  op;
        sel_t d;
        sel_t a;
        sel_t b;
        pc_t  tgt;
    } instr_t;

    typedef struct packed {
        logic load;
        logic go;
        logic emit;
        op_t  op;
        sel_t d;
        sel_t a;
        sel_t b;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic a_zero;
        logic a_one;
        logic e_lsb;
        logic p_small;
    } dp_stat_t;

    localparam pc_t PC_MULL  = 7'd7;
    localparam pc_t PC_POWL  = 7'd11;
    localparam pc_t PC_LTOP  = 7'd13;
    localparam pc_t PC_SQ    = 7'd17;
    localparam pc_t PC_INVL  = 7'd31;
    localparam pc_t PC_ELOOP = 7'd40;
    localparam pc_t PC_EFIN  = 7'd50;
    localparam pc_t PC_FAIL  = 7'd55;
    localparam pc_t PC_ZEND  = 7'd56;
    localparam pc_t PC_QM    = 7'd59;

    function automatic instr_t mk(op_t op, sel_t d, sel_t a, sel_t b, pc_t t);
        instr_t r;
        r.op  = op;
        r.d   = d;
        r.a   = a;
        r.b   = b;
        r.tgt = t;
        return r;
    endfunction

    function automatic logic is_data(op_t op);
        logic r;
        case (op)
            OP_MOD, OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_NEG, OP_MOV, OP_ONE,
            OP_ZERO, OP_LDP, OP_SHE: r = 1'b1;
            default:                 r = 1'b0;
        endcase
        return r;
    endfunction

    // Micro-program: check for a modulus of 0 or 1, reduce operands, dispatch, then run the operation.
    function automatic instr_t prog(pc_t pc);
        instr_t r;
        unique case (pc)
            7'd0:  r = mk(OP_BSMALL, SEL_XR, SEL_XR, SEL_XR, PC_ZEND);
            7'd1:  r = mk(OP_MOD,  SEL_U,  SEL_U,  SEL_XR, '0);
            7'd2:  r = mk(OP_MOD,  SEL_XR, SEL_XR, SEL_XR, '0);
            7'd3:  r = mk(OP_MOD,  SEL_XI, SEL_XI, SEL_XR, '0);
            7'd4:  r = mk(OP_MOD,  SEL_YR, SEL_YR, SEL_XR, '0);
            7'd5:  r = mk(OP_MOD,  SEL_YI, SEL_YI, SEL_XR, '0);
            7'd6:  r = mk(OP_DISP, SEL_XR, SEL_XR, SEL_XR, '0);
            // multiply
            7'd7:  r = mk(OP_MOV,  SEL_ZR, SEL_XR, SEL_XR, '0);
            7'd8:  r = mk(OP_MOV,  SEL_ZI, SEL_XI, SEL_XR, '0);
            7'd9:  r = mk(OP_CALL, SEL_XR, SEL_XR, SEL_XR, PC_QM);
            7'd10: r = mk(OP_END,  SEL_XR, SEL_XR, SEL_XR, '0);
            // power
            7'd11: r = mk(OP_ONE,  SEL_ZR, SEL_XR, SEL_XR, '0);
            7'd12: r = mk(OP_ZERO, SEL_ZI, SEL_XR, SEL_XR, '0);
            7'd13: r = mk(OP_BEB,  SEL_XR, SEL_XR, SEL_XR, PC_SQ);
            7'd14: r = mk(OP_MOV,  SEL_YR, SEL_XR, SEL_XR, '0);
            7'd15: r = mk(OP_MOV,  SEL_YI, SEL_XI, SEL_XR, '0);
            7'd16: r = mk(OP_CALL, SEL_XR, SEL_XR, SEL_XR, PC_QM);
            7'd17: r = mk(OP_MOV,  SEL_R0, SEL_ZR, SEL_XR, '0);
            7'd18: r = mk(OP_MOV,  SEL_R1, SEL_ZI, SEL_XR, '0);
            7'd19: r = mk(OP_MOV,  SEL_ZR, SEL_XR, SEL_XR, '0);
            7'd20: r = mk(OP_MOV,  SEL_ZI, SEL_XI, SEL_XR, '0);
            7'd21: r = mk(OP_MOV,  SEL_YR, SEL_XR, SEL_XR, '0);
            7'd22: r = mk(OP_MOV,  SEL_YI, SEL_XI, SEL_XR, '0);
            7'd23: r = mk(OP_CALL, SEL_XR, SEL_XR, SEL_XR, PC_QM);
            7'd24: r = mk(OP_MOV,  SEL_XR, SEL_ZR, SEL_XR, '0);
            7'd25: r = mk(OP_MOV,  SEL_XI, SEL_ZI, SEL_XR, '0);
            7'd26: r = mk(OP_MOV,  SEL_ZR, SEL_R0, SEL_XR, '0);
            7'd27: r = mk(OP_MOV,  SEL_ZI, SEL_R1, SEL_XR, '0);
            7'd28: r = mk(OP_SHE,  SEL_XR, SEL_XR, SEL_XR, '0);
            7'd29: r = mk(OP_LOOP, SEL_XR, SEL_XR, SEL_XR, PC_LTOP);
            7'd30: r = mk(OP_END,  SEL_XR, SEL_XR, SEL_XR, '0);
            // inverse: norm, then extended Euclid
            7'd31: r = mk(OP_MUL,  SEL_T0, SEL_XR, SEL_XR, '0);
            7'd32: r = mk(OP_MUL,  SEL_T1, SEL_XI, SEL_XI, '0);
            7'd33: r = mk(OP_MUL,  SEL_T1, SEL_U,  SEL_T1, '0);
            7'd34: r = mk(OP_SUB,  SEL_T0, SEL_T0, SEL_T1, '0);
            7'd35: r = mk(OP_BZ,   SEL_XR, SEL_T0, SEL_XR, PC_FAIL);
            7'd36: r = mk(OP_LDP,  SEL_R0, SEL_XR, SEL_XR, '0);
            7'd37: r = mk(OP_MOV,  SEL_R1, SEL_T0, SEL_XR, '0);
            7'd38: r = mk(OP_ZERO, SEL_A0, SEL_XR, SEL_XR, '0);
            7'd39: r = mk(OP_ONE,  SEL_A1, SEL_XR, SEL_XR, '0);
            7'd40: r = mk(OP_BZ,   SEL_XR, SEL_R1, SEL_XR, PC_EFIN);
            7'd41: r = mk(OP_DIV,  SEL_T2, SEL_R0, SEL_R1, '0);
            7'd42: r = mk(OP_MOD,  SEL_T3, SEL_Q,  SEL_XR, '0);
            7'd43: r = mk(OP_MUL,  SEL_T3, SEL_T3, SEL_A1, '0);
            7'd44: r = mk(OP_SUB,  SEL_T3, SEL_A0, SEL_T3, '0);
            7'd45: r = mk(OP_MOV,  SEL_R0, SEL_R1, SEL_XR, '0);
            7'd46: r = mk(OP_MOV,  SEL_R1, SEL_T2, SEL_XR, '0);
            7'd47: r = mk(OP_MOV,  SEL_A0, SEL_A1, SEL_XR, '0);
            7'd48: r = mk(OP_MOV,  SEL_A1, SEL_T3, SEL_XR, '0);
            7'd49: r = mk(OP_JMP,  SEL_XR, SEL_XR, SEL_XR, PC_ELOOP);
            7'd50: r = mk(OP_BNE1, SEL_XR, SEL_R0, SEL_XR, PC_FAIL);
            7'd51: r = mk(OP_MUL,  SEL_ZR, SEL_XR, SEL_A0, '0);
            7'd52: r = mk(OP_NEG,  SEL_T0, SEL_XI, SEL_XR, '0);
            7'd53: r = mk(OP_MUL,  SEL_ZI, SEL_T0, SEL_A0, '0);
            7'd54: r = mk(OP_END,  SEL_XR, SEL_XR, SEL_XR, '0);
            // failure and zero result
            7'd55: r = mk(OP_SETF, SEL_XR, SEL_XR, SEL_XR, '0);
            7'd56: r = mk(OP_ZERO, SEL_ZR, SEL_XR, SEL_XR, '0);
            7'd57: r = mk(OP_ZERO, SEL_ZI, SEL_XR, SEL_XR, '0);
            7'd58: r = mk(OP_END,  SEL_XR, SEL_XR, SEL_XR, '0);
            // subroutine: Z = Z * Y
            7'd59: r = mk(OP_MUL,  SEL_T0, SEL_ZR, SEL_YR, '0);
            7'd60: r = mk(OP_MUL,  SEL_T1, SEL_ZI, SEL_YI, '0);
            7'd61: r = mk(OP_MUL,  SEL_T1, SEL_U,  SEL_T1, '0);
            7'd62: r = mk(OP_MUL,  SEL_T2, SEL_ZR, SEL_YI, '0);
            7'd63: r = mk(OP_MUL,  SEL_T3, SEL_ZI, SEL_YR, '0);
            7'd64: r = mk(OP_ADD,  SEL_ZR, SEL_T0, SEL_T1, '0);
            7'd65: r = mk(OP_ADD,  SEL_ZI, SEL_T2, SEL_T3, '0);
            7'd66: r = mk(OP_RET,  SEL_XR, SEL_XR, SEL_XR, '0);
            default: r = mk(OP_END, SEL_XR, SEL_XR, SEL_XR, '0);
        endcase
        return r;
    endfunction

endpackage

// ===== sv/quadratic_field_mul_pow_inv_core.sv =====
// ----------------------------------------------------------------------------
// quadratic_field_mul_pow_inv_core
// Multiply, power and inverse in F_p[theta], theta^2 = u.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  in       | in_valid / in_stall   | opcode, first_*, second_*, exponent
//  out      | out_valid / out_stall | result_real, result_imag, failed
//  config   | psel/penable/pwrite   | paddr, pwdata, prdata (64 bit)
//
// Every modular multiply, reduction and division runs on one bit-serial
// engine. Reset clears the sequencer and sets modulus 3, nonresidue 2.
// A stalled output holds while the next transaction is accepted and computed.
// ----------------------------------------------------------------------------
module quadratic_field_mul_pow_inv_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  qfmpi_pkg::word_t  first_real,
    input  qfmpi_pkg::word_t  first_imag,
    input  qfmpi_pkg::word_t  second_real,
    input  qfmpi_pkg::word_t  second_imag,
    input  qfmpi_pkg::word_t  exponent,
    output logic              out_valid,
    input  logic              out_stall,
    output qfmpi_pkg::word_t  result_real,
    output qfmpi_pkg::word_t  result_imag,
    output logic              failed,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import qfmpi_pkg::*;

    word_t    modulus_reg;
    word_t    nonresidue_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg    <= word_t'(3);
            nonresidue_reg <= word_t'(2);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3])
            begin
                nonresidue_reg <= pwdata[WORD_BITS-1:0];
            end
            else
            begin
                modulus_reg <= pwdata[WORD_BITS-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = 64'(paddr[3] ? nonresidue_reg : modulus_reg);

    qfmpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .failed    (failed),
        .cmd       (cmd),
        .stat      (stat)
    );

    qfmpi_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .first_real  (first_real),
        .first_imag  (first_imag),
        .second_real (second_real),
        .second_imag (second_imag),
        .exponent    (exponent),
        .modulus     (modulus_reg),
        .nonresidue  (nonresidue_reg),
        .result_real (result_real),
        .result_imag (result_imag)
    );

endmodule

// ===== sv/qfmpi_datapath.sv =====
// ----------------------------------------------------------------------------
// qfmpi_datapath
// Operand registers, combinational modular add/sub and a bit-serial engine for
// modular multiply, reduction and integer division.
// ----------------------------------------------------------------------------
module qfmpi_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  qfmpi_pkg::dp_cmd_t cmd,
    output qfmpi_pkg::dp_stat_t stat,
    input  qfmpi_pkg::word_t   first_real,
    input  qfmpi_pkg::word_t   first_imag,
    input  qfmpi_pkg::word_t   second_real,
    input  qfmpi_pkg::word_t   second_imag,
    input  qfmpi_pkg::word_t   exponent,
    input  qfmpi_pkg::word_t   modulus,
    input  qfmpi_pkg::word_t   nonresidue,
    output qfmpi_pkg::word_t   result_real,
    output qfmpi_pkg::word_t   result_imag
);
    import qfmpi_pkg::*;

    function automatic word_t addm(word_t x, word_t y, word_t p);
        logic [WORD_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p})
        begin
            s = s - {1'b0, p};
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t subm(word_t x, word_t y, word_t p);
        word_t r;
        r = x - y;
        if (x < y)
        begin
            r = r + p;
        end
        return r;
    endfunction

    word_t xr_reg, xi_reg, yr_reg, yi_reg, zr_reg, zi_reg, u_reg, t0_reg;
    word_t t1_reg, t2_reg, t3_reg, r0_reg, r1_reg, a0_reg, a1_reg, q_reg;
    word_t e_reg;
    word_t res_re_reg, res_im_reg;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] ecnt_reg, ecnt_next;
    word_t            acc_reg, acc_next;
    word_t            sh_reg, sh_next;
    word_t            k_reg, k_next;
    word_t            qacc_reg, qacc_next;
    op_t              eop_reg, eop_next;
    sel_t             edst_reg, edst_next;

    word_t a_val, b_val;
    logic  wr_en, q_wr, e_shift;
    sel_t  wr_sel;
    word_t wr_data;

    word_t              dbl, mstep, dstep, acc_step;
    logic [WORD_BITS:0] rem;
    logic               ge;

    function automatic word_t rd(sel_t s, word_t xr, word_t xi, word_t yr, word_t yi,
                                 word_t zr, word_t zi, word_t u, word_t t0, word_t t1,
                                 word_t t2, word_t t3, word_t r0, word_t r1, word_t a0,
                                 word_t a1, word_t q);
        word_t r;
        unique case (s)
            SEL_XR: r = xr;
            SEL_XI: r = xi;
            SEL_YR: r = yr;
            SEL_YI: r = yi;
            SEL_ZR: r = zr;
            SEL_ZI: r = zi;
            SEL_U:  r = u;
            SEL_T0: r = t0;
            SEL_T1: r = t1;
            SEL_T2: r = t2;
            SEL_T3: r = t3;
            SEL_R0: r = r0;
            SEL_R1: r = r1;
            SEL_A0: r = a0;
            SEL_A1: r = a1;
            default: r = q;
        endcase
        return r;
    endfunction

    always_comb
    begin
        a_val = rd(cmd.a, xr_reg, xi_reg, yr_reg, yi_reg, zr_reg, zi_reg, u_reg, t0_reg,
                   t1_reg, t2_reg, t3_reg, r0_reg, r1_reg, a0_reg, a1_reg, q_reg);
        b_val = rd(cmd.b, xr_reg, xi_reg, yr_reg, yi_reg, zr_reg, zi_reg, u_reg, t0_reg,
                   t1_reg, t2_reg, t3_reg, r0_reg, r1_reg, a0_reg, a1_reg, q_reg);
    end

    // one engine step: double-and-add, or shift-subtract
    always_comb
    begin
        dbl      = addm(acc_reg, acc_reg, modulus);
        mstep    = sh_reg[WORD_BITS-1] ? addm(dbl, k_reg, modulus) : dbl;
        rem      = {acc_reg, sh_reg[WORD_BITS-1]};
        ge       = (rem >= {1'b0, k_reg});
        dstep    = ge ? word_t'(rem - {1'b0, k_reg}) : rem[WORD_BITS-1:0];
        acc_step = (eop_reg == OP_MUL) ? mstep : dstep;
    end

    always_comb
    begin
        busy_next = busy_reg;
        ecnt_next = ecnt_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        k_next    = k_reg;
        qacc_next = qacc_reg;
        eop_next  = eop_reg;
        edst_next = edst_reg;
        wr_en     = 1'b0;
        wr_sel    = cmd.d;
        wr_data   = '0;
        q_wr      = 1'b0;
        e_shift   = 1'b0;
        if (busy_reg)
        begin
            ecnt_next = ecnt_reg + 1'b1;
            sh_next   = {sh_reg[WORD_BITS-2:0], 1'b0};
            acc_next  = acc_step;
            qacc_next = {qacc_reg[WORD_BITS-2:0], ge};
            if (ecnt_reg == CNT_W'(WORD_BITS - 1))
            begin
                busy_next = 1'b0;
                wr_en     = 1'b1;
                wr_sel    = edst_reg;
                wr_data   = acc_step;
                q_wr      = (eop_reg == OP_DIV);
            end
        end
        else if (cmd.go)
        begin
            case (cmd.op)
                OP_MOD, OP_MUL, OP_DIV:
                begin
                    busy_next = 1'b1;
                    ecnt_next = '0;
                    acc_next  = '0;
                    qacc_next = '0;
                    eop_next  = cmd.op;
                    edst_next = cmd.d;
                    sh_next   = (cmd.op == OP_MUL) ? b_val : a_val;
                    k_next    = (cmd.op == OP_MUL) ? a_val :
                                (cmd.op == OP_DIV) ? b_val : modulus;
                end
                OP_ADD:  begin wr_en = 1'b1; wr_data = addm(a_val, b_val, modulus); end
                OP_SUB:  begin wr_en = 1'b1; wr_data = subm(a_val, b_val, modulus); end
                OP_NEG:  begin wr_en = 1'b1; wr_data = subm('0, a_val, modulus); end
                OP_MOV:  begin wr_en = 1'b1; wr_data = a_val; end
                OP_ONE:  begin wr_en = 1'b1; wr_data = word_t'(1); end
                OP_ZERO: begin wr_en = 1'b1; wr_data = '0; end
                OP_LDP:  begin wr_en = 1'b1; wr_data = modulus; end
                OP_SHE:  e_shift = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ecnt_reg <= ecnt_next;
        acc_reg  <= acc_next;
        sh_reg   <= sh_next;
        k_reg    <= k_next;
        qacc_reg <= qacc_next;
        eop_reg  <= eop_next;
        edst_reg <= edst_next;
        if (q_wr)
        begin
            q_reg <= {qacc_reg[WORD_BITS-2:0], ge};
        end
        if (cmd.emit)
        begin
            res_re_reg <= zr_reg;
            res_im_reg <= zi_reg;
        end
        if (cmd.load)
        begin
            xr_reg <= first_real;
            xi_reg <= first_imag;
            yr_reg <= second_real;
            yi_reg <= second_imag;
            u_reg  <= nonresidue;
            e_reg  <= exponent;
        end
        else
        begin
            if (e_shift)
            begin
                e_reg <= e_reg >> 1;
            end
            if (wr_en)
            begin
                unique case (wr_sel)
                    SEL_XR: xr_reg <= wr_data;
                    SEL_XI: xi_reg <= wr_data;
                    SEL_YR: yr_reg <= wr_data;
                    SEL_YI: yi_reg <= wr_data;
                    SEL_ZR: zr_reg <= wr_data;
                    SEL_ZI: zi_reg <= wr_data;
                    SEL_U:  u_reg  <= wr_data;
                    SEL_T0: t0_reg <= wr_data;
                    SEL_T1: t1_reg <= wr_data;
                    SEL_T2: t2_reg <= wr_data;
                    SEL_T3: t3_reg <= wr_data;
                    SEL_R0: r0_reg <= wr_data;
                    SEL_R1: r1_reg <= wr_data;
                    SEL_A0: a0_reg <= wr_data;
                    SEL_A1: a1_reg <= wr_data;
                    default: q_reg <= wr_data;
                endcase
            end
        end
    end

    assign stat.busy    = busy_reg;
    assign stat.a_zero  = (a_val == '0);
    assign stat.a_one   = (a_val == word_t'(1));
    assign stat.e_lsb   = e_reg[0];
    assign stat.p_small = (modulus <= word_t'(1));

    assign result_real = res_re_reg;
    assign result_imag = res_im_reg;

endmodule

// ===== sv/qfmpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// qfmpi_ctrl
// Micro-program sequencer: runs the program, handles branches, calls and the
// exponent loop, and owns both handshakes.
// ----------------------------------------------------------------------------
module qfmpi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          opcode,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                failed,
    output qfmpi_pkg::dp_cmd_t  cmd,
    input  qfmpi_pkg::dp_stat_t stat
);
    import qfmpi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_END  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    pc_t              pc_reg, pc_next;
    pc_t              ret_reg, ret_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    opc_t             opc_reg, opc_next;
    logic             fail_reg, fail_next;
    logic             out_valid_reg, out_valid_next;
    logic             failed_reg, failed_next;
    instr_t           ins;

    always_comb
    begin
        ins            = prog(pc_reg);
        state_next     = state_reg;
        pc_next        = pc_reg;
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        opc_next       = opc_reg;
        fail_next      = fail_reg;
        out_valid_next = out_valid_reg;
        failed_next    = failed_reg;
        cmd.load       = 1'b0;
        cmd.go         = 1'b0;
        cmd.emit       = 1'b0;
        cmd.op         = ins.op;
        cmd.d          = ins.d;
        cmd.a          = ins.a;
        cmd.b          = ins.b;

        // drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    opc_next   = opc_t'(opcode);
                    pc_next    = '0;
                    cnt_next   = '0;
                    fail_next  = 1'b0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (is_data(ins.op))
                begin
                    cmd.go     = 1'b1;
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    pc_next = pc_reg + 1'b1;
                    case (ins.op)
                        OP_BSMALL:
                        begin
                            if (stat.p_small)
                            begin
                                fail_next = (opc_reg == OPC_INV);
                                pc_next   = ins.tgt;
                            end
                        end
                        OP_DISP:
                        begin
                            unique case (opc_reg)
                                OPC_MUL: pc_next = PC_MULL;
                                OPC_POW: pc_next = PC_POWL;
                                OPC_INV: pc_next = PC_INVL;
                                default: pc_next = PC_FAIL;
                            endcase
                        end
                        OP_BZ:   if (stat.a_zero) pc_next = ins.tgt;
                        OP_BNE1: if (!stat.a_one) pc_next = ins.tgt;
                        OP_BEB:  if (!stat.e_lsb) pc_next = ins.tgt;
                        OP_LOOP:
                        begin
                            if (cnt_reg != CNT_W'(WORD_BITS - 1))
                            begin
                                cnt_next = cnt_reg + 1'b1;
                                pc_next  = ins.tgt;
                            end
                        end
                        OP_JMP:  pc_next = ins.tgt;
                        OP_CALL:
                        begin
                            ret_next = pc_reg + 1'b1;
                            pc_next  = ins.tgt;
                        end
                        OP_RET:  pc_next = ret_reg;
                        OP_SETF: fail_next = 1'b1;
                        default: state_next = ST_END;
                    endcase
                end
            end
            ST_WAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = ST_EXEC;
                end
            end
            default:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    failed_next    = fail_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg     <= pc_next;
        ret_reg    <= ret_next;
        cnt_reg    <= cnt_next;
        opc_reg    <= opc_next;
        fail_reg   <= fail_next;
        failed_reg <= failed_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign failed    = failed_reg;

endmodule

// ===== sv/qfmpi_chk.sv =====
// ----------------------------------------------------------------------------
// qfmpi_chk
// Port-level checks for the quadratic extension field unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qfmpi_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input qfmpi_pkg::word_t  result_real,
    input qfmpi_pkg::word_t  result_imag,
    input logic              failed
);
    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

    // a failed transaction carries a zero element
    `ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && failed, result_real == '0 && result_imag == '0, "failed result not zero")

    // one transaction in flight: the input closes right after accept
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input open after accept")

endmodule

bind quadratic_field_mul_pow_inv_core qfmpi_chk u_qfmpi_chk (.*);

// ===== tb/quadratic_field_mul_pow_inv_core_test.sv =====
// ----------------------------------------------------------------------------
// quadratic_field_mul_pow_inv_core_test
// Drives multiply, power and inverse requests through the quadratic field core
// under several modulus/non-residue settings and idling patterns, predicts
// each result with 128-bit modular arithmetic and checks it field by field.
// ----------------------------------------------------------------------------
module quadratic_field_mul_pow_inv_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import qfmpi_pkg::*;

    localparam int          CYCLE_LIMIT = 40_000_000;
    localparam int          DRAIN_WAIT  = 200;
    localparam logic [3:0]  ADDR_MODULUS    = 4'd0;
    localparam logic [3:0]  ADDR_NONRESIDUE = 4'd8;

    typedef struct packed {
        word_t re;
        word_t im;
    } felem_t;

    typedef struct packed {
        word_t re;
        word_t im;
        logic  fail;
    } qresult_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    word_t       first_real;
    word_t       first_imag;
    word_t       second_real;
    word_t       second_imag;
    word_t       exponent;
    logic        out_valid;
    logic        out_stall;
    word_t       result_real;
    word_t       result_imag;
    logic        failed;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // predictor copy of the field registers
    word_t       field_p;
    word_t       field_u;

    qresult_t    pending_results[$];
    int          error_count;
    int          cycle_count;
    int          sent_count;
    int          checked_count;
    int          op_count[4];
    int          idle_pct;
    int          stall_pct;

    quadratic_field_mul_pow_inv_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .first_real  (first_real),
        .first_imag  (first_imag),
        .second_real (second_real),
        .second_imag (second_imag),
        .exponent    (exponent),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_real (result_real),
        .result_imag (result_imag),
        .failed      (failed),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------ field math
    function automatic word_t mod_mul(word_t a, word_t b, word_t p);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return word_t'(prod % {64'd0, p});
    endfunction

    function automatic word_t mod_add(word_t a, word_t b, word_t p);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        return s[63:0];
    endfunction

    function automatic word_t mod_sub(word_t a, word_t b, word_t p);
        return (a >= b) ? a - b : p - (b - a);
    endfunction

    function automatic felem_t felem_mul(felem_t x, felem_t y, word_t u, word_t p);
        felem_t z;
        z.re = mod_add(mod_mul(x.re, y.re, p), mod_mul(u, mod_mul(x.im, y.im, p), p), p);
        z.im = mod_add(mod_mul(x.re, y.im, p), mod_mul(x.im, y.re, p), p);
        return z;
    endfunction

    function automatic felem_t felem_pow(felem_t x, word_t e, word_t u, word_t p);
        felem_t z;
        z.re = 64'd1;
        z.im = 64'd0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (e[i])
                z = felem_mul(z, x, u, p);
            x = felem_mul(x, x, u, p);
        end
        return z;
    endfunction

    // inverse of n modulo p, 0 when gcd(n, p) is not 1
    function automatic word_t scalar_inverse(word_t n, word_t p);
        word_t r_prev, r_cur, c_prev, c_cur, quo, r_next, c_next;
        r_prev = p;
        r_cur  = n;
        c_prev = 64'd0;
        c_cur  = 64'd1;
        while (r_cur != 0)
        begin
            quo    = r_prev / r_cur;
            r_next = r_prev % r_cur;
            c_next = mod_sub(c_prev, mod_mul(quo % p, c_cur, p), p);
            r_prev = r_cur;
            r_cur  = r_next;
            c_prev = c_cur;
            c_cur  = c_next;
        end
        return (r_prev == 64'd1) ? c_prev : 64'd0;
    endfunction

    function automatic qresult_t predict_field_op(logic [1:0] op, word_t ar, word_t ai,
                                                  word_t br, word_t bi, word_t e);
        qresult_t r;
        felem_t   x, y, z;
        word_t    u, norm, ninv;
        r = '0;
        if (field_p <= 64'd1)
        begin
            r.fail = (op == OPC_INV);
            return r;
        end
        u    = field_u % field_p;
        x.re = ar % field_p;
        x.im = ai % field_p;
        y.re = br % field_p;
        y.im = bi % field_p;
        case (op)
            OPC_MUL:
            begin
                z    = felem_mul(x, y, u, field_p);
                r.re = z.re;
                r.im = z.im;
            end
            OPC_POW:
            begin
                z    = felem_pow(x, e, u, field_p);
                r.re = z.re;
                r.im = z.im;
            end
            OPC_INV:
            begin
                norm = mod_sub(mod_mul(x.re, x.re, field_p),
                               mod_mul(u, mod_mul(x.im, x.im, field_p), field_p), field_p);
                ninv = (norm != 0) ? scalar_inverse(norm, field_p) : 64'd0;
                if (ninv == 0)
                    r.fail = 1'b1;
                else
                begin
                    r.re = mod_mul(x.re, ninv, field_p);
                    r.im = mod_mul((x.im != 0) ? field_p - x.im : 64'd0, ninv, field_p);
                end
            end
            default:
                r.fail = 1'b1;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------ drivers
    task automatic send_request(logic [1:0] op, word_t ar, word_t ai,
                                word_t br, word_t bi, word_t e);
        bit dropped;
        dropped = 0;
        while ($urandom_range(99) < idle_pct)
        begin
            if (!dropped)
                in_valid <= 1'b0;
            dropped = 1;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        first_real  <= ar;
        first_imag  <= ai;
        second_real <= br;
        second_imag <= bi;
        exponent    <= e;
        // wait for the transaction to be taken
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_field_op(op, ar, ai, br, bi, e));
        sent_count++;
        op_count[op]++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_register(logic [3:0] addr, word_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MODULUS)
            field_p = value;
        else
            field_u = value;
    endtask

    task automatic set_field(word_t p, word_t u);
        wait_drained();
        write_register(ADDR_MODULUS, p);
        write_register(ADDR_NONRESIDUE, u);
    endtask

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic word_t pick_operand();
        word_t w;
        case ($urandom_range(7))
            0:       w = 64'd0;
            1:       w = field_p - 64'd1;
            2:       w = field_p;
            3:       w = '1;
            4:       w = 64'($urandom_range(9));
            default: w = rand_word();
        endcase
        return w;
    endfunction

    function automatic word_t pick_exponent();
        word_t w;
        case ($urandom_range(5))
            0:       w = 64'd0;
            1:       w = 64'd1;
            2:       w = '1;
            3:       w = 64'($urandom_range(16));
            default: w = rand_word();
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------ result check
    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            qresult_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result re=%h im=%h failed=%b",
                         $time, result_real, result_imag, failed);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (result_real !== want.re)
                begin
                    $display("%0t: result_real expected %h actual %h", $time, want.re, result_real);
                    error_count++;
                end
                if (result_imag !== want.im)
                begin
                    $display("%0t: result_imag expected %h actual %h", $time, want.im, result_imag);
                    error_count++;
                end
                if (failed !== want.fail)
                begin
                    $display("%0t: failed expected %b actual %b", $time, want.fail, failed);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("quadratic_field_mul_pow_inv_core_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------ tests
    task automatic test_reset_field();
        // defaults p = 3, u = 2
        send_request(OPC_MUL, '1, '1, '1, '1, 64'd0);
        send_request(OPC_MUL, 64'd0, 64'd0, 64'd0, 64'd0, '1);
        send_request(OPC_POW, 64'd2, 64'd1, rand_word(), rand_word(), 64'd0);
        send_request(OPC_POW, 64'd2, 64'd1, rand_word(), rand_word(), '1);
        send_request(OPC_INV, 64'd0, 64'd0, rand_word(), rand_word(), rand_word());
        send_request(OPC_INV, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0);
        send_request(OPC_INV, 64'd5, 64'd7, '1, '1, '1);
        send_request(OPC_BAD, rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    task automatic test_large_prime();
        set_field(64'hFFFF_FFFF_FFFF_FFC5, 64'd3);
        send_request(OPC_MUL, '1, '1, '1, '1, 64'd0);
        send_request(OPC_MUL, 64'hFFFF_FFFF_FFFF_FFC4, 64'h1, 64'hFFFF_FFFF_FFFF_FFC4, 64'h1,
                     64'd0);
        send_request(OPC_INV, 64'd0, 64'd1, 64'd0, 64'd0, 64'd0);
        send_request(OPC_INV, rand_word(), rand_word(), 64'd0, 64'd0, 64'd0);
        send_request(OPC_POW, rand_word(), rand_word(), 64'd0, 64'd0, 64'd2);
        send_request(OPC_BAD, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
    endtask

    task automatic test_degenerate_modulus();
        // composite: norm 9 shares a factor with 15, norm 2 does not
        set_field(64'd15, 64'd2);
        send_request(OPC_INV, 64'd3, 64'd0, 64'd0, 64'd0, 64'd0);
        send_request(OPC_INV, 64'd2, 64'd1, 64'd0, 64'd0, 64'd0);
        set_field(64'd0, 64'd5);
        send_request(OPC_MUL, 64'd3, 64'd4, 64'd5, 64'd6, 64'd0);
        send_request(OPC_INV, 64'd3, 64'd4, 64'd5, 64'd6, 64'd0);
        set_field(64'd1, '1);
        send_request(OPC_POW, 64'd3, 64'd4, 64'd5, 64'd6, '1);
        send_request(OPC_INV, 64'd3, 64'd4, 64'd5, 64'd6, 64'd0);
        send_request(OPC_BAD, 64'd3, 64'd4, 64'd5, 64'd6, 64'd0);
    endtask

    task automatic test_random_fields();
        word_t field_list[10][2];
        int    pick;
        logic [1:0] op;
        field_list = '{'{64'd3, 64'd2}, '{64'd5, 64'd2}, '{64'd7, 64'd3},
                       '{64'd13, 64'd2}, '{64'd15, 64'd7}, '{64'd65521, 64'd17},
                       '{64'h1FFF_FFFF_FFFF_FFFF, 64'd3},
                       '{64'hFFFF_FFFF_FFFF_FFC5, 64'd0},
                       '{'1, '1}, '{64'd0, 64'd1}};
        for (int f = 0; f < 10; f++)
        begin
            set_field(field_list[f][0], (f % 3 == 2) ? rand_word() : field_list[f][1]);
            for (int n = 0; n < 84; n++)
            begin
                case (n / 21)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 85; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 85; end
                    default: begin idle_pct = 35; stall_pct = 35; end
                endcase
                // power walks all exponent bits, so keep it rare
                pick = $urandom_range(199);
                if (pick < 2)
                    op = OPC_POW;
                else if (pick < 6)
                    op = OPC_BAD;
                else if (pick < 50)
                    op = OPC_INV;
                else
                    op = OPC_MUL;
                send_request(op, pick_operand(), pick_operand(), pick_operand(),
                             pick_operand(), pick_exponent());
            end
            if (f == 4)
            begin
                // hold off until the pipeline is empty, then continue
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = OPC_MUL;
        first_real  = '0;
        first_imag  = '0;
        second_real = '0;
        second_imag = '0;
        exponent    = '0;
        out_stall   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        field_p     = 64'd3;
        field_u     = 64'd2;
        idle_pct    = 0;
        stall_pct   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_field();
        test_large_prime();
        test_degenerate_modulus();
        test_random_fields();
        wait_drained();

        $display("Sent %0d requests (mul %0d, pow %0d, inv %0d, unused %0d), checked %0d results",
                 sent_count, op_count[OPC_MUL], op_count[OPC_POW], op_count[OPC_INV],
                 op_count[OPC_BAD], checked_count);
        $display("Covered prime, composite and degenerate moduli under four idling patterns");
        if (error_count == 0 && pending_results.size() == 0)
            $display("quadratic_field_mul_pow_inv_core_test passed");
        else
            $display("quadratic_field_mul_pow_inv_core_test failed");
        $finish;
    end

endmodule
